/* sv/fbc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared constants, codes and types of the cascaded peaking biquad block.
// ----------------------------------------------------------------------------
package fbc_pkg;

    localparam int SECTIONS_DEF    = 6;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 32;

    // Section histories and the value passed between sections are 32 bits.
    localparam int HIST_BITS  = 32;
    // Integer bits of a coefficient; the rest of COEF_BITS is fraction.
    localparam int COEF_INT   = 8;
    localparam int SEL_BITS   = 2;

    localparam int LEVEL_BITS = 16;
    localparam int LEVEL_FRAC = 12;
    localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 16'd4096;

    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    // Word index of the output level register (paddr bit 2).
    localparam logic REG_OUTPUT_LEVEL = 1'b0;

    typedef enum logic {
        FUNC_SAMPLE = 1'b0,
        FUNC_COEF   = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        CS_AB1 = 2'd0,
        CS_A2  = 2'd1,
        CS_B0  = 2'd2,
        CS_B2  = 2'd3
    } t_coef_sel;

    // Second operand of the shared multiplier.
    typedef enum logic [2:0] {
        TERM_X    = 3'd0,
        TERM_X1   = 3'd1,
        TERM_X2   = 3'd2,
        TERM_Y1   = 3'd3,
        TERM_Y2   = 3'd4,
        TERM_GAIN = 3'd5
    } t_term;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_SEC      = 2'd1,
        ST_GAIN_MUL = 2'd2,
        ST_GAIN_RND = 2'd3
    } t_state;

    typedef struct packed {
        logic signed [HIST_BITS-1:0] x1;
        logic signed [HIST_BITS-1:0] x2;
        logic signed [HIST_BITS-1:0] y1;
        logic signed [HIST_BITS-1:0] y2;
    } t_hist_row;

    typedef struct packed {
        logic  x_load;
        logic  mul_en;
        t_term term;
        logic  acc_en;
        logic  acc_clr;
        logic  acc_sub;
        logic  sec_done;
        logic  out_load;
    } t_mac_ctl;

endpackage
`default_nettype wire

/* sv/fbc_coef_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbc_coef_mem
// Coefficient store, four entries per section, with a valid bit per entry.
// ----------------------------------------------------------------------------
module fbc_coef_mem #(
    parameter int SECTIONS  = 6,
    parameter int COEF_BITS = 32,
    parameter int CA_W      = 5
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_we,
    input  wire logic [CA_W-1:0]             i_waddr,
    input  wire logic signed [COEF_BITS-1:0] i_wdata,
    input  wire logic                        i_re,
    input  wire logic [CA_W-1:0]             i_raddr,
    output logic signed [COEF_BITS-1:0]      o_q
);
    import fbc_pkg::*;

    localparam int DEPTH = SECTIONS * 4;
    localparam logic [COEF_BITS-1:0] COEF_ONE =
        {{(COEF_BITS-1){1'b0}}, 1'b1} << (COEF_BITS - COEF_INT);

    logic [COEF_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]     r_valid;
    logic [COEF_BITS-1:0] r_rd_data;
    logic                 r_rd_valid;
    logic                 r_rd_b0;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_data  <= mem[i_raddr];
            r_rd_b0    <= (t_coef_sel'(i_raddr[SEL_BITS-1:0]) == CS_B0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_valid <= r_valid[i_raddr];
            end
        end
    end

    // An entry never written reads as its reset value: b0 is one, others zero.
    always_comb begin
        if (r_rd_valid) begin
            o_q = r_rd_data;
        end else if (r_rd_b0) begin
            o_q = COEF_ONE;
        end else begin
            o_q = '0;
        end
    end

endmodule
`default_nettype wire

/* sv/fbc_hist_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbc_hist_mem
// Section history store, one row of x1, x2, y1, y2 per section.
// ----------------------------------------------------------------------------
module fbc_hist_mem #(
    parameter int SECTIONS = 6,
    parameter int SIDX_W   = 3
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_re,
    input  wire logic                 i_we,
    input  wire logic [SIDX_W-1:0]    i_addr,
    input  fbc_pkg::t_hist_row        i_wdata,
    output fbc_pkg::t_hist_row        o_q
);
    import fbc_pkg::*;

    t_hist_row         mem [SECTIONS];
    logic [SECTIONS-1:0] r_valid;
    t_hist_row         r_rd_data;
    logic              r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_data <= mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_addr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_valid <= r_valid[i_addr];
            end
        end
    end

    // A row never written holds zero history.
    assign o_q = r_rd_valid ? r_rd_data : '0;

endmodule
`default_nettype wire

/* sv/fbc_mac.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbc_mac
// Shared multiplier, accumulator and rounding/saturation datapath.
// ----------------------------------------------------------------------------
module fbc_mac #(
    parameter int COEF_BITS   = 32,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          i_clk,
    input  fbc_pkg::t_mac_ctl                  i_ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic signed [COEF_BITS-1:0]   i_coef,
    input  fbc_pkg::t_hist_row                 i_hist,
    input  wire logic [fbc_pkg::LEVEL_BITS-1:0] i_level,
    output fbc_pkg::t_hist_row                 o_hist_wr,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out
);
    import fbc_pkg::*;

    localparam int FRAC   = COEF_BITS - COEF_INT;
    localparam int PROD_W = COEF_BITS + HIST_BITS;
    localparam int ACC_W  = PROD_W + 3;
    localparam int SH_W   = ACC_W - FRAC;
    localparam int G_W    = PROD_W - LEVEL_FRAC;

    localparam logic [ACC_W-1:0]  ACC_HALF  = {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC - 1);
    localparam logic [PROD_W-1:0] GAIN_HALF =
        {{(PROD_W-1){1'b0}}, 1'b1} << (LEVEL_FRAC - 1);
    localparam logic signed [HIST_BITS-1:0] Y_MAX = {1'b0, {(HIST_BITS-1){1'b1}}};
    localparam logic signed [HIST_BITS-1:0] Y_MIN = {1'b1, {(HIST_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [HIST_BITS-1:0]   r_x;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [SAMPLE_BITS-1:0] r_out;

    logic signed [COEF_BITS-1:0]   op_a;
    logic signed [HIST_BITS-1:0]   op_b;
    logic signed [PROD_W-1:0]      n_prod;
    logic signed [ACC_W-1:0]       prod_ext;
    logic signed [ACC_W-1:0]       acc_base;
    logic signed [ACC_W-1:0]       n_acc;
    logic [ACC_W-1:0]              acc_rnd;
    logic [SH_W-1:0]               y_sh;
    logic signed [HIST_BITS-1:0]   y_sat;
    logic [PROD_W-1:0]             g_rnd;
    logic [G_W-1:0]                g_sh;
    logic signed [SAMPLE_BITS-1:0] g_sat;

    always_comb begin
        op_a = i_coef;
        case (i_ctl.term)
            TERM_X:    op_b = r_x;
            TERM_X1:   op_b = i_hist.x1;
            TERM_X2:   op_b = i_hist.x2;
            TERM_Y1:   op_b = i_hist.y1;
            TERM_Y2:   op_b = i_hist.y2;
            TERM_GAIN: begin
                op_a = COEF_BITS'({1'b0, i_level});
                op_b = r_x;
            end
            default:   op_b = r_x;
        endcase
        n_prod = PROD_W'(op_a) * PROD_W'(op_b);
    end

    // Feedback terms are subtracted rather than negating the coefficient.
    always_comb begin
        prod_ext = ACC_W'(r_prod);
        acc_base = i_ctl.acc_clr ? '0 : r_acc;
        n_acc    = i_ctl.acc_sub ? (acc_base - prod_ext) : (acc_base + prod_ext);
    end

    // Round half up to the history fraction, then clamp to 32 bits.
    always_comb begin
        acc_rnd = r_acc + ACC_HALF;
        y_sh    = acc_rnd[ACC_W-1:FRAC];
        if ((&y_sh[SH_W-1:HIST_BITS-1]) || !(|y_sh[SH_W-1:HIST_BITS-1])) begin
            y_sat = y_sh[HIST_BITS-1:0];
        end else if (y_sh[SH_W-1]) begin
            y_sat = Y_MIN;
        end else begin
            y_sat = Y_MAX;
        end
    end

    // Output gain: round half up by the level fraction, clamp to the sample.
    always_comb begin
        g_rnd = r_prod + GAIN_HALF;
        g_sh  = g_rnd[PROD_W-1:LEVEL_FRAC];
        if ((&g_sh[G_W-1:SAMPLE_BITS-1]) || !(|g_sh[G_W-1:SAMPLE_BITS-1])) begin
            g_sat = g_sh[SAMPLE_BITS-1:0];
        end else if (g_sh[G_W-1]) begin
            g_sat = S_MIN;
        end else begin
            g_sat = S_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.x_load) begin
            r_x <= HIST_BITS'(i_sample);
        end else if (i_ctl.sec_done) begin
            r_x <= y_sat;
        end
        if (i_ctl.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_ctl.acc_en) begin
            r_acc <= n_acc;
        end
        if (i_ctl.out_load) begin
            r_out <= g_sat;
        end
    end

    always_comb begin
        o_hist_wr.x1 = r_x;
        o_hist_wr.x2 = i_hist.x1;
        o_hist_wr.y1 = y_sat;
        o_hist_wr.y2 = i_hist.y1;
    end

    assign o_sample_out = r_out;

endmodule
`default_nettype wire

/* sv/fbc_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbc_seq
// Sequencer: walks the sections, schedules memory reads and the shared MAC.
// ----------------------------------------------------------------------------
module fbc_seq #(
    parameter int SECTIONS = 6,
    parameter int SIDX_W   = 3
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_out_stall,
    output logic                   o_busy,
    output logic                   o_out_valid,
    output logic [SIDX_W-1:0]      o_sec,
    output logic                   o_coef_re,
    output fbc_pkg::t_coef_sel     o_coef_sel,
    output logic                   o_hist_re,
    output logic                   o_hist_we,
    output fbc_pkg::t_mac_ctl      o_ctl
);
    import fbc_pkg::*;

    localparam logic [SIDX_W-1:0] SEC_LAST = SIDX_W'(SECTIONS - 1);
    localparam logic [2:0]        PH_LAST  = 3'd7;

    t_state            r_state, n_state;
    logic [2:0]        r_ph, n_ph;
    logic [SIDX_W-1:0] r_sec, n_sec;
    logic              r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ph        <= '0;
            r_sec       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ph        <= n_ph;
            r_sec       <= n_sec;
            r_out_valid <= n_out_valid;
        end
    end

    // Per section: phases 0-4 read coefficients, 1-5 multiply, 2-6
    // accumulate, 7 rounds and writes the history row back.
    always_comb begin
        n_state     = r_state;
        n_ph        = r_ph;
        n_sec       = r_sec;
        n_out_valid = r_out_valid & i_out_stall;
        o_coef_re   = 1'b0;
        o_coef_sel  = CS_B0;
        o_hist_re   = 1'b0;
        o_hist_we   = 1'b0;
        o_ctl       = '0;
        o_ctl.term  = TERM_X;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_ctl.x_load = 1'b1;
                    n_state      = ST_SEC;
                    n_ph         = '0;
                    n_sec        = '0;
                end
            end
            ST_SEC: begin
                o_coef_re = (r_ph <= 3'd4);
                o_hist_re = (r_ph == 3'd0);
                case (r_ph)
                    3'd0:    o_coef_sel = CS_B0;
                    3'd1:    o_coef_sel = CS_AB1;
                    3'd2:    o_coef_sel = CS_B2;
                    3'd3:    o_coef_sel = CS_AB1;
                    3'd4:    o_coef_sel = CS_A2;
                    default: o_coef_sel = CS_B0;
                endcase
                case (r_ph)
                    3'd1:    o_ctl.term = TERM_X;
                    3'd2:    o_ctl.term = TERM_X1;
                    3'd3:    o_ctl.term = TERM_X2;
                    3'd4:    o_ctl.term = TERM_Y1;
                    3'd5:    o_ctl.term = TERM_Y2;
                    default: o_ctl.term = TERM_X;
                endcase
                o_ctl.mul_en   = (r_ph >= 3'd1) && (r_ph <= 3'd5);
                o_ctl.acc_en   = (r_ph >= 3'd2) && (r_ph <= 3'd6);
                o_ctl.acc_clr  = (r_ph == 3'd2);
                o_ctl.acc_sub  = (r_ph == 3'd5) || (r_ph == 3'd6);
                o_ctl.sec_done = (r_ph == PH_LAST);
                o_hist_we      = (r_ph == PH_LAST);
                n_ph           = r_ph + 3'd1;
                if (r_ph == PH_LAST) begin
                    if (r_sec == SEC_LAST) begin
                        n_sec   = '0;
                        n_state = ST_GAIN_MUL;
                    end else begin
                        n_sec = r_sec + SIDX_W'(1);
                    end
                end
            end
            ST_GAIN_MUL: begin
                o_ctl.mul_en = 1'b1;
                o_ctl.term   = TERM_GAIN;
                n_state      = ST_GAIN_RND;
            end
            ST_GAIN_RND: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_ctl.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_sec       = r_sec;

endmodule
`default_nettype wire

/* sv/formant_biquad_cascade.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// formant_biquad_cascade
// Cascade of peaking biquad sections with output gain and saturation.
// ----------------------------------------------------------------------------
// Each audio beat (func = 0) carries a signed Q1.23 sample that runs through
// SECTIONS biquad sections in turn, y = b0*x + ab1*x1 + b2*x2 - ab1*y1 - a2*y2,
// each rounded half up and clamped to 32 bits, and the last section's output
// is multiplied by output_level (unsigned Q4.12), rounded and clamped to the
// sample range; each audio beat gives exactly one output beat. A coefficient
// beat (func = 1) writes one Q8.24 coefficient of one section, gives no
// output, and is ignored when the section number is out of range. All five
// products of every section go through one shared multiplier and one
// accumulator, so the sections are worked one after another, and o_stall is
// high from the accept of an audio beat until its result is loaded into the
// output register. A coefficient beat is written into the coefficient store
// as it is accepted. The finished sample sits in an output register, so
// the next sample is accepted while it waits; only if it is still not taken
// when the following sample finishes does the block hold. Coefficients and
// histories live in small memories whose entries carry valid bits, so they
// read as pass-through coefficients and zero history right after reset,
// without any clearing pass. output_level is written through the APB port at
// byte address 0 and should only be changed while the block is idle.
// ----------------------------------------------------------------------------
module formant_biquad_cascade #(
    parameter int SECTIONS    = fbc_pkg::SECTIONS_DEF,
    parameter int SAMPLE_BITS = fbc_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = fbc_pkg::COEF_BITS_DEF,
    localparam int SEC_W      = ($clog2(SECTIONS) > 3) ? $clog2(SECTIONS) : 3
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Input channel.
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_func,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_sample_in,
    input  wire logic [SEC_W-1:0]                i_section,
    input  wire logic [fbc_pkg::SEL_BITS-1:0]    i_coef_select,
    input  wire logic signed [COEF_BITS-1:0]     i_coef_value,
    // Output channel.
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic signed [SAMPLE_BITS-1:0]        o_sample_out,
    // Register port.
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fbc_pkg::PADDR_BITS-1:0]  paddr,
    input  wire logic [fbc_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [fbc_pkg::PDATA_BITS-1:0]       prdata,
    output logic                                 pready
);
    import fbc_pkg::*;

    localparam int SIDX_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int CA_W   = SIDX_W + SEL_BITS;

    logic [LEVEL_BITS-1:0] r_level;

    logic                  in_accept;
    logic                  start;
    logic                  coef_we;
    logic                  busy;
    logic [SIDX_W-1:0]     sec;
    logic                  coef_re;
    t_coef_sel             coef_sel;
    logic                  hist_re;
    logic                  hist_we;
    t_mac_ctl              mac_ctl;
    logic signed [COEF_BITS-1:0] coef_q;
    t_hist_row             hist_q;
    t_hist_row             hist_wr;

    // The output level register is the only register; paddr bit 2 is its
    // word index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= LEVEL_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_OUTPUT_LEVEL)) begin
            r_level <= pwdata[LEVEL_BITS-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OUTPUT_LEVEL) ?
                    {{(PDATA_BITS-LEVEL_BITS){1'b0}}, r_level} : '0;

    // Both kinds of beat are taken only while the sequencer is idle.
    assign o_stall   = busy;
    assign in_accept = i_valid && !busy;
    assign start     = in_accept && (t_func'(i_func) == FUNC_SAMPLE);
    assign coef_we   = in_accept && (t_func'(i_func) == FUNC_COEF)
                       && ((SEC_W+1)'(i_section) < (SEC_W+1)'(SECTIONS));

    fbc_seq #(
        .SECTIONS (SECTIONS),
        .SIDX_W   (SIDX_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_out_stall (i_stall),
        .o_busy      (busy),
        .o_out_valid (o_valid),
        .o_sec       (sec),
        .o_coef_re   (coef_re),
        .o_coef_sel  (coef_sel),
        .o_hist_re   (hist_re),
        .o_hist_we   (hist_we),
        .o_ctl       (mac_ctl)
    );

    fbc_coef_mem #(
        .SECTIONS  (SECTIONS),
        .COEF_BITS (COEF_BITS),
        .CA_W      (CA_W)
    ) u_coef_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (coef_we),
        .i_waddr ({i_section[SIDX_W-1:0], i_coef_select}),
        .i_wdata (i_coef_value),
        .i_re    (coef_re),
        .i_raddr ({sec, coef_sel}),
        .o_q     (coef_q)
    );

    fbc_hist_mem #(
        .SECTIONS (SECTIONS),
        .SIDX_W   (SIDX_W)
    ) u_hist_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (hist_re),
        .i_we    (hist_we),
        .i_addr  (sec),
        .i_wdata (hist_wr),
        .o_q     (hist_q)
    );

    fbc_mac #(
        .COEF_BITS   (COEF_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk        (i_clk),
        .i_ctl        (mac_ctl),
        .i_sample     (i_sample_in),
        .i_coef       (coef_q),
        .i_hist       (hist_q),
        .i_level      (r_level),
        .o_hist_wr    (hist_wr),
        .o_sample_out (o_sample_out)
    );

endmodule
`default_nettype wire
